// ----- rtl/nipd_pkg.sv -----
// ----------------------------------------------------------------------------
// NEC IR pulse decoder package
// Shared widths, register defaults, register indexes and decoder phase codes.
// ----------------------------------------------------------------------------
package nipd_pkg;

  localparam int DUR_W     = 15;   // pulse duration width, microseconds
  localparam int DUR_PAD_W = 16;   // duration padded to whole bytes
  localparam int FRAME_W   = 32;   // result frame width
  localparam int CFG_IDX_W = 3;    // register index width

  // Default timing windows, microseconds
  localparam logic [DUR_W-1:0] RST_LEADER_MARK_MIN  = 15'd7000;
  localparam logic [DUR_W-1:0] RST_LEADER_MARK_MAX  = 15'd11000;
  localparam logic [DUR_W-1:0] RST_LEADER_SPACE_MIN = 15'd3500;
  localparam logic [DUR_W-1:0] RST_LEADER_SPACE_MAX = 15'd5500;
  localparam logic [DUR_W-1:0] RST_BIT_MARK_MIN     = 15'd300;
  localparam logic [DUR_W-1:0] RST_BIT_MARK_MAX     = 15'd900;
  localparam logic [DUR_W-1:0] RST_ONE_SPACE_THRESH = 15'd1000;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEADER_MARK_MIN  = 3'd0,
    REG_LEADER_MARK_MAX  = 3'd1,
    REG_LEADER_SPACE_MIN = 3'd2,
    REG_LEADER_SPACE_MAX = 3'd3,
    REG_BIT_MARK_MIN     = 3'd4,
    REG_BIT_MARK_MAX     = 3'd5,
    REG_ONE_SPACE_THRESH = 3'd6
  } cfg_idx_t;

  // Decoder phase
  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_MARK  = 2'd1,
    PH_SPACE = 2'd2
  } phase_t;

  // Timing register set
  typedef struct packed {
    logic [DUR_W-1:0] leader_mark_min;
    logic [DUR_W-1:0] leader_mark_max;
    logic [DUR_W-1:0] leader_space_min;
    logic [DUR_W-1:0] leader_space_max;
    logic [DUR_W-1:0] bit_mark_min;
    logic [DUR_W-1:0] bit_mark_max;
    logic [DUR_W-1:0] one_space_thresh;
  } cfg_regs_t;

endpackage

// ----- rtl/nipd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// NEC IR pulse decoder timing registers
// Seven 15-bit timing windows written through the configuration channel.
// ----------------------------------------------------------------------------
module nipd_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [nipd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nipd_pkg::DUR_W-1:0]           cfg_data,
  output nipd_pkg::cfg_regs_t                  regs
);
  import nipd_pkg::*;

  // Writes are always accepted; cfg_ready is tied high
  assign cfg_ready = 1'b1;

  // Register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.leader_mark_min  <= RST_LEADER_MARK_MIN;
      regs.leader_mark_max  <= RST_LEADER_MARK_MAX;
      regs.leader_space_min <= RST_LEADER_SPACE_MIN;
      regs.leader_space_max <= RST_LEADER_SPACE_MAX;
      regs.bit_mark_min     <= RST_BIT_MARK_MIN;
      regs.bit_mark_max     <= RST_BIT_MARK_MAX;
      regs.one_space_thresh <= RST_ONE_SPACE_THRESH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        REG_LEADER_MARK_MIN:  regs.leader_mark_min  <= cfg_data;
        REG_LEADER_MARK_MAX:  regs.leader_mark_max  <= cfg_data;
        REG_LEADER_SPACE_MIN: regs.leader_space_min <= cfg_data;
        REG_LEADER_SPACE_MAX: regs.leader_space_max <= cfg_data;
        REG_BIT_MARK_MIN:     regs.bit_mark_min     <= cfg_data;
        REG_BIT_MARK_MAX:     regs.bit_mark_max     <= cfg_data;
        REG_ONE_SPACE_THRESH: regs.one_space_thresh <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/nipd_core.sv -----
// ----------------------------------------------------------------------------
// NEC IR pulse decoder core
// Leader hunt, bit mark check and bit space sampling; one duration per step.
// ----------------------------------------------------------------------------
module nipd_core #(
  parameter int FRAME_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  nipd_pkg::cfg_regs_t            regs,
  input  logic                           step,
  input  logic [nipd_pkg::DUR_W-1:0]     duration,
  output logic                           emit,
  output logic [nipd_pkg::FRAME_W-1:0]   frame
);
  import nipd_pkg::*;

  localparam int IDX_W = $clog2(FRAME_BITS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BITS - 1);

  phase_t                  phase, phase_next;
  logic [DUR_W-1:0]        prev_dur, prev_dur_next;
  logic [IDX_W-1:0]        bit_index, bit_index_next;
  logic [FRAME_BITS-1:0]   shift_value, shift_value_next;
  logic [FRAME_BITS-1:0]   shift_set;
  logic                    leader_hit;
  logic                    mark_ok;

  // Window compares
  assign leader_hit = (prev_dur > regs.leader_mark_min) && (prev_dur < regs.leader_mark_max)
                   && (duration > regs.leader_space_min)
                   && (duration < regs.leader_space_max);
  assign mark_ok    = (duration >= regs.bit_mark_min) && (duration <= regs.bit_mark_max);

  // Shift register with the current bit merged in
  always_comb begin
    shift_set = shift_value;
    if (duration > regs.one_space_thresh) begin
      shift_set[bit_index] = 1'b1;
    end
  end

  assign frame = FRAME_W'(shift_set);

  // Next state and frame strobe
  always_comb begin
    phase_next       = phase;
    prev_dur_next    = prev_dur;
    bit_index_next   = bit_index;
    shift_value_next = shift_value;
    emit             = 1'b0;
    case (phase)
      PH_MARK: begin
        if (mark_ok) begin
          phase_next = PH_SPACE;
        end else begin
          phase_next     = PH_HUNT;
          prev_dur_next  = duration;
          bit_index_next = '0;
        end
      end
      PH_SPACE: begin
        if (bit_index == LAST_IDX) begin
          emit             = 1'b1;
          phase_next       = PH_HUNT;
          prev_dur_next    = '0;
          bit_index_next   = '0;
          shift_value_next = '0;
        end else begin
          shift_value_next = shift_set;
          bit_index_next   = bit_index + 1'b1;
          phase_next       = PH_MARK;
        end
      end
      default: begin
        // hunting; the unused code behaves the same
        if (leader_hit) begin
          phase_next       = PH_MARK;
          prev_dur_next    = '0;
          bit_index_next   = '0;
          shift_value_next = '0;
        end else begin
          phase_next    = PH_HUNT;
          prev_dur_next = duration;
        end
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      prev_dur    <= '0;
      bit_index   <= '0;
      shift_value <= '0;
    end else if (step) begin
      phase       <= phase_next;
      prev_dur    <= prev_dur_next;
      bit_index   <= bit_index_next;
      shift_value <= shift_value_next;
    end
  end

endmodule

// ----- rtl/nec_ir_pulse_decoder.sv -----
// ----------------------------------------------------------------------------
// NEC IR pulse decoder
// Decodes NEC frames from a stream of mark/space durations in microseconds.
// ----------------------------------------------------------------------------
// Output: a frame is registered on m_tdata, m_tvalid high, once the beat of its last
//   space has passed from the input register through the core into the output register.
// Throughput: one duration beat per cycle, set by the input register feeding the
//   decoder core; s_tready drops only while a finished frame waits on m_tready.
// Reset (rst, synchronous): decoder returns to leader hunt, pipeline and output
//   registers empty, timing registers back to their default windows.
module nec_ir_pulse_decoder #(
  parameter int FRAME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,     // [14:0] duration_us, [15] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,     // [31:0] frame_value
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data
);
  import nipd_pkg::*;

  cfg_regs_t           regs;
  logic                in_valid;
  logic [DUR_W-1:0]    in_dur;
  logic                in_go;
  logic                out_free;
  logic                emit;
  logic [FRAME_W-1:0]  frame;

  nipd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  // Handshake between input register, core and output register
  assign out_free = !m_tvalid || m_tready;
  assign in_go    = in_valid && (!emit || out_free);
  assign s_tready = !in_valid || in_go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_dur <= s_tdata[DUR_W-1:0];
    end
  end

  nipd_core #(
    .FRAME_BITS (FRAME_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .regs     (regs),
    .step     (in_go),
    .duration (in_dur),
    .emit     (emit),
    .frame    (frame)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_go && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_go && emit) begin
      m_tdata <= frame;
    end
  end

endmodule

// ----- rtl/nipd_checker.sv -----
// ----------------------------------------------------------------------------
// NEC IR pulse decoder port checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module nipd_checker #(
  parameter int FRAME_BITS = 32
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // Input back-pressure only comes from a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a stalled result");

  // A fresh result follows an accepted input beat, passed on through the input and output registers
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a causing input beat");

  // Frame bits above the frame length stay clear
  a_out_width: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata >> FRAME_BITS) == 32'd0)
    else $error("result has bits beyond the frame length");

endmodule

bind nec_ir_pulse_decoder nipd_checker #(
  .FRAME_BITS (FRAME_BITS)
) u_nipd_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata)
);
